// ===== rtl/rrws_pkg.sv =====
// Shared types and constants of the round-robin I/O wait scheduler.
package rrws_pkg;

    localparam int RRWS_MAX_PROCESSES = 16;

    localparam int ID_W   = 4;
    localparam int CLK_W  = 32;
    localparam int SWO_W  = 8;
    localparam int IOL_W  = 16;
    localparam int STAT_W = 3;
    localparam int ELAP_W = 16;
    localparam int CFG_W  = 16;

    localparam logic [SWO_W-1:0] SWO_RESET = 8'd5;
    localparam logic [IOL_W-1:0] IOL_RESET = 16'd28;

    localparam logic CFG_SWITCH_OVERHEAD = 1'b0;
    localparam logic CFG_IO_LATENCY      = 1'b1;

    typedef enum logic [1:0] {
        OP_ADMIT    = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_REPORT   = 2'd2
    } op_t;

    localparam logic [STAT_W-1:0] ST_SLICE_END = 3'd0;
    localparam logic [STAT_W-1:0] ST_READ      = 3'd6;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SATADD
    } alu_op_t;

endpackage

// ===== rtl/rrws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rrws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/rrws_alu.sv =====
// Shared 32-bit add, subtract-compare and saturating-add unit.
module rrws_alu
    import rrws_pkg::*;
(
    input  alu_op_t          op,
    input  logic [CLK_W-1:0] a,
    input  logic [CLK_W-1:0] b,
    output logic [CLK_W-1:0] y,
    output logic             flag
);

    logic [CLK_W:0] sum;
    logic [CLK_W:0] diff;

    always_comb
    begin
        sum  = {1'b0, a} + {1'b0, b};
        diff = {1'b0, a} - {1'b0, b};
        unique case (op)
            ALU_ADD:
            begin
                y    = sum[CLK_W-1:0];
                flag = sum[CLK_W];
            end
            ALU_SUB:
            begin
                y    = diff[CLK_W-1:0];
                flag = diff[CLK_W];  // borrow: a < b
            end
            ALU_SATADD:
            begin
                y    = sum[CLK_W] ? {CLK_W{1'b1}} : sum[CLK_W-1:0];
                flag = sum[CLK_W];
            end
            default:
            begin
                y    = sum[CLK_W-1:0];
                flag = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/round_robin_io_wait_scheduler.sv =====
// Round-robin process scheduler with an I/O wait queue: top level.
//
// One item is worked at a time; s_tready is high only while the sequencer is idle.
// An admit writes the queue and per-process memories. A dispatch pops the ready queue and
// adds the stamp difference to the wait total. A report adds the elapsed time, then the
// switch overhead, moves due waiters to the ready queue, acts on the status and then
// dispatches. A report with nothing running, a dispatch while a process runs, or an unused
// operation goes straight to the output step. Moving a waiter takes a compare, a subtract
// and an accumulate step; a wait head not yet due stops at its compare. A dispatch that
// finds the ready queue empty while waiters remain first takes an idle-forward step. The
// single shared 32-bit adder does the elapsed-time and overhead clock advances, stamp
// differences, due-time compares and saturating totals; the queue and per-process
// memories have registered reads. A finished result waits in the output register while
// the next item is taken. A new result is held back until the previous one is accepted,
// so a receiver stall adds to the item time. No clearing pass is needed after reset.
module round_robin_io_wait_scheduler
    import rrws_pkg::*;
#(
    parameter int MAX_PROCESSES = RRWS_MAX_PROCESSES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // process_id[3:0], elapsed_cycles[19:4], return_status[22:20]
    input  logic [1:0]   s_tuser,   // operation[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // running_process[3:0], all_done[4], retired_process[8:5],
                                    // retired_wait_time[40:9], retired_io_time[72:41],
                                    // clock_now[104:73]
    output logic [1:0]   m_tuser    // running_valid[0], retired_valid[1]
);

    localparam int PW = $clog2(MAX_PROCESSES);
    localparam int CW = $clog2(MAX_PROCESSES + 1);
    localparam int OW = 105;

    typedef enum logic [4:0] {
        S_IDLE, S_ADMIT,
        S_REP_ADD, S_REP_OVH, S_REP_ADDR, S_REP_ACT,
        S_DSP_CHK, S_FWD, S_DSP_SEL, S_DSP_POP, S_DSP_SUB, S_DSP_ACC,
        S_DRN_CHK, S_DRN_CMP, S_DRN_SUB, S_DRN_ACC,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [SWO_W-1:0]  swo_reg;
    logic [IOL_W-1:0]  iol_reg;
    logic [CLK_W-1:0]  clock_reg;
    logic [PW-1:0]     rq_head_reg;
    logic [CW-1:0]     rq_cnt_reg;
    logic [PW-1:0]     wq_head_reg;
    logic [CW-1:0]     wq_cnt_reg;
    logic              cur_valid_reg;
    logic [PW-1:0]     cur_proc_reg;
    logic [PW-1:0]     p_reg;
    logic [CLK_W-1:0]  tmp_reg;
    logic              drn_ret_rep_reg;

    logic [ID_W-1:0]   pid_reg;
    logic [ELAP_W-1:0] elap_reg;
    logic [STAT_W-1:0] stat_reg;

    logic              run_v_reg;
    logic [ID_W-1:0]   run_p_reg;
    logic              ret_v_reg;
    logic [ID_W-1:0]   ret_p_reg;
    logic [CLK_W-1:0]  ret_w_reg;
    logic [CLK_W-1:0]  ret_io_reg;

    logic              m_tvalid_reg;
    logic [OW-1:0]     m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    alu_op_t           alu_op;
    logic [CLK_W-1:0]  alu_a;
    logic [CLK_W-1:0]  alu_b;
    logic [CLK_W-1:0]  alu_y;
    logic              alu_flag;

    logic              rq_we;
    logic [PW-1:0]     rq_wdata;
    logic [PW-1:0]     rq_rdata;
    logic              wq_we;
    logic [PW-1:0]     wq_id_rdata;
    logic [CLK_W-1:0]  wq_done_rdata;
    logic              stamp_we;
    logic              wtot_we;
    logic              iotot_we;
    logic [CLK_W-1:0]  wtot_wdata;
    logic [CLK_W-1:0]  iotot_wdata;
    logic [PW-1:0]     pp_waddr;
    logic [PW-1:0]     pp_raddr;
    logic [CLK_W-1:0]  stamp_rdata;
    logic [CLK_W-1:0]  wtot_rdata;
    logic [CLK_W-1:0]  iotot_rdata;

    logic              rq_room;
    logic              wq_room;
    logic              admit_ok;
    logic [PW-1:0]     pid_idx;
    logic [PW-1:0]     rq_slot;
    logic [PW-1:0]     wq_slot;
    logic              in_acc;
    logic              out_free;

    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] h, input logic [CW-1:0] c);
        logic [CW:0] s;
        begin
            s = (CW+1)'(h) + (CW+1)'(c);
            if (s >= (CW+1)'(MAX_PROCESSES))
            begin
                s = s - (CW+1)'(MAX_PROCESSES);
            end
            slot_of = PW'(s);
        end
    endfunction

    assign rq_room  = rq_cnt_reg < CW'(MAX_PROCESSES);
    assign wq_room  = wq_cnt_reg < CW'(MAX_PROCESSES);
    assign pid_idx  = PW'(pid_reg);
    assign admit_ok = (32'(pid_reg) < 32'(MAX_PROCESSES)) && rq_room;
    assign rq_slot  = slot_of(rq_head_reg, rq_cnt_reg);
    assign wq_slot  = slot_of(wq_head_reg, wq_cnt_reg);
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_tdata_reg};
    assign m_tuser  = m_tuser_reg;

    rrws_alu u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .y    (alu_y),
        .flag (alu_flag)
    );

    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = clock_reg;
        alu_b  = '0;
        unique case (state_reg)
            S_REP_ADD: alu_b = 32'(elap_reg);
            S_REP_OVH: alu_b = 32'(swo_reg);
            S_REP_ACT: alu_b = 32'(iol_reg);
            S_DRN_CMP, S_FWD:
            begin
                alu_op = ALU_SUB;
                alu_b  = wq_done_rdata;
            end
            S_DRN_SUB, S_DSP_SUB:
            begin
                alu_op = ALU_SUB;
                alu_b  = stamp_rdata;
            end
            S_DRN_ACC:
            begin
                alu_op = ALU_SATADD;
                alu_a  = iotot_rdata;
                alu_b  = tmp_reg;
            end
            S_DSP_ACC:
            begin
                alu_op = ALU_SATADD;
                alu_a  = wtot_rdata;
                alu_b  = tmp_reg;
            end
            default: alu_b = '0;
        endcase
    end

    always_comb
    begin
        rq_we       = 1'b0;
        rq_wdata    = p_reg;
        wq_we       = 1'b0;
        stamp_we    = 1'b0;
        wtot_we     = 1'b0;
        iotot_we    = 1'b0;
        wtot_wdata  = alu_y;
        iotot_wdata = alu_y;
        pp_waddr    = p_reg;
        pp_raddr    = p_reg;
        unique case (state_reg)
            S_ADMIT:
            begin
                pp_waddr    = pid_idx;
                rq_wdata    = pid_idx;
                wtot_wdata  = '0;
                iotot_wdata = '0;
                rq_we       = admit_ok;
                stamp_we    = admit_ok;
                wtot_we     = admit_ok;
                iotot_we    = admit_ok;
            end
            S_DRN_CMP: pp_raddr = wq_id_rdata;
            S_DRN_ACC:
            begin
                rq_we    = 1'b1;
                stamp_we = 1'b1;
                iotot_we = 1'b1;
            end
            S_REP_ADDR: pp_raddr = cur_proc_reg;
            S_REP_ACT:
            begin
                if (stat_reg == ST_SLICE_END)
                begin
                    rq_we    = rq_room;
                    stamp_we = rq_room;
                end
                else if (stat_reg >= ST_READ)
                begin
                    wq_we    = wq_room;
                    stamp_we = wq_room;
                end
            end
            S_DSP_POP: pp_raddr = rq_rdata;
            S_DSP_ACC:
            begin
                stamp_we = 1'b1;
                wtot_we  = 1'b1;
            end
            default: pp_raddr = p_reg;
        endcase
    end

    rrws_ram #(.WIDTH(PW), .DEPTH(MAX_PROCESSES)) u_rq_mem (
        .clk(clk), .we(rq_we), .waddr(rq_slot), .wdata(rq_wdata),
        .raddr(rq_head_reg), .rdata(rq_rdata)
    );

    rrws_ram #(.WIDTH(PW), .DEPTH(MAX_PROCESSES)) u_wq_id_mem (
        .clk(clk), .we(wq_we), .waddr(wq_slot), .wdata(p_reg),
        .raddr(wq_head_reg), .rdata(wq_id_rdata)
    );

    rrws_ram #(.WIDTH(CLK_W), .DEPTH(MAX_PROCESSES)) u_wq_done_mem (
        .clk(clk), .we(wq_we), .waddr(wq_slot), .wdata(alu_y),
        .raddr(wq_head_reg), .rdata(wq_done_rdata)
    );

    rrws_ram #(.WIDTH(CLK_W), .DEPTH(MAX_PROCESSES)) u_stamp_mem (
        .clk(clk), .we(stamp_we), .waddr(pp_waddr), .wdata(clock_reg),
        .raddr(pp_raddr), .rdata(stamp_rdata)
    );

    rrws_ram #(.WIDTH(CLK_W), .DEPTH(MAX_PROCESSES)) u_wtot_mem (
        .clk(clk), .we(wtot_we), .waddr(pp_waddr), .wdata(wtot_wdata),
        .raddr(pp_raddr), .rdata(wtot_rdata)
    );

    rrws_ram #(.WIDTH(CLK_W), .DEPTH(MAX_PROCESSES)) u_iotot_mem (
        .clk(clk), .we(iotot_we), .waddr(pp_waddr), .wdata(iotot_wdata),
        .raddr(pp_raddr), .rdata(iotot_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            swo_reg         <= SWO_RESET;
            iol_reg         <= IOL_RESET;
            clock_reg       <= '0;
            rq_head_reg     <= '0;
            rq_cnt_reg      <= '0;
            wq_head_reg     <= '0;
            wq_cnt_reg      <= '0;
            cur_valid_reg   <= 1'b0;
            drn_ret_rep_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SWITCH_OVERHEAD)
                begin
                    swo_reg <= cfg_data[SWO_W-1:0];
                end
                else
                begin
                    iol_reg <= cfg_data[IOL_W-1:0];
                end
            end

            // S_DONE reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        pid_reg    <= s_tdata[3:0];
                        elap_reg   <= s_tdata[19:4];
                        stat_reg   <= s_tdata[22:20];
                        run_v_reg  <= 1'b0;
                        run_p_reg  <= '0;
                        ret_v_reg  <= 1'b0;
                        ret_p_reg  <= '0;
                        ret_w_reg  <= '0;
                        ret_io_reg <= '0;
                        unique case (s_tuser)
                            OP_ADMIT:    state_reg <= S_ADMIT;
                            OP_DISPATCH: state_reg <= cur_valid_reg ? S_DONE : S_DSP_CHK;
                            OP_REPORT:   state_reg <= cur_valid_reg ? S_REP_ADD : S_DONE;
                            default:     state_reg <= S_DONE;
                        endcase
                    end
                end
                S_ADMIT:
                begin
                    if (admit_ok)
                    begin
                        rq_cnt_reg <= rq_cnt_reg + CW'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_REP_ADD:
                begin
                    clock_reg <= alu_y;
                    state_reg <= S_REP_OVH;
                end
                S_REP_OVH:
                begin
                    clock_reg       <= alu_y;
                    cur_valid_reg   <= 1'b0;
                    drn_ret_rep_reg <= 1'b1;
                    state_reg       <= S_DRN_CHK;
                end
                S_DRN_CHK:
                begin
                    if (wq_cnt_reg != '0 && rq_room)
                    begin
                        state_reg <= S_DRN_CMP;
                    end
                    else
                    begin
                        state_reg <= drn_ret_rep_reg ? S_REP_ADDR : S_DSP_SEL;
                    end
                end
                S_DRN_CMP:
                begin
                    if (alu_flag)
                    begin
                        state_reg <= drn_ret_rep_reg ? S_REP_ADDR : S_DSP_SEL;
                    end
                    else
                    begin
                        p_reg       <= wq_id_rdata;
                        wq_head_reg <= slot_of(wq_head_reg, CW'(1));
                        wq_cnt_reg  <= wq_cnt_reg - CW'(1);
                        state_reg   <= S_DRN_SUB;
                    end
                end
                S_DRN_SUB:
                begin
                    tmp_reg   <= alu_y;
                    state_reg <= S_DRN_ACC;
                end
                S_DRN_ACC:
                begin
                    rq_cnt_reg <= rq_cnt_reg + CW'(1);
                    state_reg  <= S_DRN_CHK;
                end
                S_REP_ADDR:
                begin
                    p_reg     <= cur_proc_reg;
                    state_reg <= S_REP_ACT;
                end
                S_REP_ACT:
                begin
                    if (stat_reg == ST_SLICE_END)
                    begin
                        if (rq_room)
                        begin
                            rq_cnt_reg <= rq_cnt_reg + CW'(1);
                        end
                    end
                    else if (stat_reg >= ST_READ)
                    begin
                        if (wq_room)
                        begin
                            wq_cnt_reg <= wq_cnt_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        ret_v_reg  <= 1'b1;
                        ret_p_reg  <= ID_W'(cur_proc_reg);
                        ret_w_reg  <= wtot_rdata;
                        ret_io_reg <= iotot_rdata;
                    end
                    state_reg <= S_DSP_CHK;
                end
                S_DSP_CHK:
                begin
                    if (rq_cnt_reg == '0 && wq_cnt_reg != '0)
                    begin
                        state_reg <= S_FWD;
                    end
                    else
                    begin
                        state_reg <= S_DSP_SEL;
                    end
                end
                S_FWD:
                begin
                    if (alu_flag)
                    begin
                        clock_reg <= wq_done_rdata;
                    end
                    drn_ret_rep_reg <= 1'b0;
                    state_reg       <= S_DRN_CHK;
                end
                S_DSP_SEL:
                begin
                    state_reg <= (rq_cnt_reg == '0) ? S_DONE : S_DSP_POP;
                end
                S_DSP_POP:
                begin
                    p_reg       <= rq_rdata;
                    rq_head_reg <= slot_of(rq_head_reg, CW'(1));
                    rq_cnt_reg  <= rq_cnt_reg - CW'(1);
                    state_reg   <= S_DSP_SUB;
                end
                S_DSP_SUB:
                begin
                    tmp_reg   <= alu_y;
                    state_reg <= S_DSP_ACC;
                end
                S_DSP_ACC:
                begin
                    cur_proc_reg  <= p_reg;
                    cur_valid_reg <= 1'b1;
                    run_v_reg     <= 1'b1;
                    run_p_reg     <= ID_W'(p_reg);
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= {ret_v_reg, run_v_reg};
                        m_tdata_reg  <= {clock_reg, ret_io_reg, ret_w_reg, ret_p_reg,
                                         (rq_cnt_reg == '0) && (wq_cnt_reg == '0)
                                             && !cur_valid_reg,
                                         run_p_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/rrws_checker.sv =====
// Port-level assertions for the scheduler, bound to the top level.
module rrws_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // a dispatch leaves a process running
    a_run_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tdata[4])
        else $error("all_done with a process running");

    // retire fields are zero without a retire
    a_ret_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata[72:5] == '0)
        else $error("retire fields set without retire");

endmodule

bind round_robin_io_wait_scheduler rrws_checker u_rrws_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for round_robin_io_wait_scheduler: directed table, then random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rrws_pkg::*;

    localparam int NPROC       = RRWS_MAX_PROCESSES;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 100;
    localparam int EXP_DEPTH   = 16;

    localparam logic [1:0]        OP_UNUSED     = 2'd3;
    localparam logic [STAT_W-1:0] ST_HALT       = 3'd1;
    localparam logic [STAT_W-1:0] ST_BOUNDS     = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW   = 3'd3;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW  = 3'd4;
    localparam logic [STAT_W-1:0] ST_BAD_OPCODE = 3'd5;
    localparam logic [STAT_W-1:0] ST_WRITE      = 3'd7;

    typedef struct packed {
        logic        run_v;
        logic [3:0]  run_p;
        logic        all_done;
        logic        ret_v;
        logic [3:0]  ret_p;
        logic [31:0] ret_w;
        logic [31:0] ret_io;
        logic [31:0] clk_now;
    } sched_result_t;

    typedef struct {
        logic [1:0]    op;
        logic [3:0]    pid;
        logic [15:0]   el;
        logic [2:0]    st;
        bit            typed;
        sched_result_t want;
    } dir_row_t;

    localparam sched_result_t BLANK = '0;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [15:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;

    round_robin_io_wait_scheduler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // scheduler shadow state
    logic [3:0]  rdy_q     [NPROC] = '{default: '0};
    logic [3:0]  io_q_id   [NPROC] = '{default: '0};
    logic [31:0] io_q_done [NPROC] = '{default: '0};
    logic [31:0] stamp     [NPROC] = '{default: '0};
    logic [31:0] wtot      [NPROC] = '{default: '0};
    logic [31:0] iotot     [NPROC] = '{default: '0};
    int          rdy_head = 0, rdy_cnt = 0, io_head = 0, io_cnt = 0;
    logic [31:0] sclk = '0;
    logic [3:0]  cur_p = '0;
    bit          cur_v = 1'b0;
    logic [7:0]  p_swo = SWO_RESET;
    logic [15:0] p_iol = IOL_RESET;

    // expected results, oldest first
    sched_result_t exp_buf [EXP_DEPTH];
    int            exp_head = 0, exp_cnt = 0;

    int n_items = 0, n_results = 0, mism = 0;
    int n_dispatched = 0, n_retired = 0, n_parked = 0, n_idle_fwd = 0, n_dropped = 0;

    function automatic logic [31:0] sat_acc(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    function automatic bit rdy_push(logic [3:0] p);
        if (rdy_cnt >= NPROC)
            return 1'b0;
        rdy_q[(rdy_head + rdy_cnt) % NPROC] = p;
        rdy_cnt++;
        stamp[p] = sclk;
        return 1'b1;
    endfunction

    function automatic void drain_done_io();
        logic [3:0] p;
        while (io_cnt > 0 && rdy_cnt < NPROC) begin
            p = io_q_id[io_head];
            if (io_q_done[io_head] > sclk)
                break;
            io_head = (io_head + 1) % NPROC;
            io_cnt--;
            iotot[p] = sat_acc(iotot[p], sclk - stamp[p]);
            void'(rdy_push(p));
        end
    endfunction

    function automatic bit dispatch_next(output logic [3:0] who);
        who = '0;
        if (rdy_cnt == 0 && io_cnt > 0) begin
            if (io_q_done[io_head] > sclk) begin
                sclk = io_q_done[io_head];
                n_idle_fwd++;
            end
            drain_done_io();
        end
        if (rdy_cnt == 0)
            return 1'b0;
        who = rdy_q[rdy_head];
        rdy_head = (rdy_head + 1) % NPROC;
        rdy_cnt--;
        wtot[who] = sat_acc(wtot[who], sclk - stamp[who]);
        stamp[who] = sclk;
        cur_p = who;
        cur_v = 1'b1;
        n_dispatched++;
        return 1'b1;
    endfunction

    function automatic sched_result_t predict_sched_step(logic [1:0] op, logic [3:0] pid,
                                                         logic [15:0] el, logic [2:0] st);
        sched_result_t r;
        logic [3:0]    p, nxt;
        int            slot;
        r = '0;
        if (op == OP_ADMIT) begin
            if (rdy_cnt < NPROC) begin
                wtot[pid] = '0;
                iotot[pid] = '0;
                void'(rdy_push(pid));
            end
        end else if (op == OP_DISPATCH) begin
            if (!cur_v) begin
                r.run_v = dispatch_next(nxt);
                r.run_p = nxt;
            end
        end else if (op == OP_REPORT && cur_v) begin
            p = cur_p;
            sclk = sclk + 32'(el) + 32'(p_swo);
            drain_done_io();
            cur_v = 1'b0;
            cur_p = '0;
            if (st == ST_SLICE_END) begin
                if (!rdy_push(p))
                    n_dropped++;
            end else if (st == ST_READ || st == ST_WRITE) begin
                if (io_cnt < NPROC) begin
                    slot = (io_head + io_cnt) % NPROC;
                    io_q_id[slot] = p;
                    io_q_done[slot] = sclk + 32'(p_iol);
                    io_cnt++;
                    stamp[p] = sclk;
                    n_parked++;
                end else begin
                    n_dropped++;
                end
            end else begin
                r.ret_v = 1'b1;
                r.ret_p = p;
                r.ret_w = wtot[p];
                r.ret_io = iotot[p];
                n_retired++;
            end
            r.run_v = dispatch_next(nxt);
            r.run_p = nxt;
        end
        r.all_done = (rdy_cnt == 0 && io_cnt == 0 && !cur_v);
        r.clk_now = sclk;
        return r;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [3:0] pid, input logic [15:0] el,
                             input logic [2:0] st, input bit typed, input sched_result_t want);
        sched_result_t pred;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, st, el, pid};
        do
            @(posedge clk);
        while (!s_tready);
        pred = predict_sched_step(op, pid, el, st);
        exp_buf[(exp_head + exp_cnt) % EXP_DEPTH] = typed ? want : pred;
        exp_cnt++;
        n_items++;
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_SWITCH_OVERHEAD)
            p_swo = val[7:0];
        else
            p_iol = val;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (exp_cnt != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] swo, input logic [15:0] iol, input int target,
                             input int io_bias, input int small_pct);
        int          sent, burst, gap, r, fill;
        logic [1:0]  op;
        logic [3:0]  pid;
        logic [15:0] el;
        logic [2:0]  st;
        sent = 0;
        burst = 0;
        fill = 0;
        hold_until_drained();
        write_cfg(CFG_SWITCH_OVERHEAD, {8'd0, swo});
        write_cfg(CFG_IO_LATENCY, iol);
        @(negedge clk);
        cfg_we <= 1'b0;
        while (sent < target) begin
            if (burst == 0) begin
                burst = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 20);
                gap = $urandom_range(1, 24);
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst--;
            pid = 4'($urandom);
            r = $urandom_range(0, 99);
            if (r < small_pct)
                el = 16'($urandom_range(0, 60));
            else if (r < small_pct + 4)
                el = r[0] ? 16'hFFFF : 16'h0000;
            else
                el = 16'($urandom);
            r = $urandom_range(0, 99);
            if (r < io_bias)
                st = $urandom_range(0, 1) ? ST_READ : ST_WRITE;
            else if (r < io_bias + (100 - io_bias) * 2 / 3)
                st = ST_SLICE_END;
            else
                st = 3'($urandom_range(ST_HALT, ST_BAD_OPCODE));
            r = $urandom_range(0, 99);
            if (fill == 0 && r == 0)
                fill = NPROC + 2;   // overfill the ready queue
            if (r >= 94)
                op = 2'($urandom);
            else if (fill > 0) begin
                op = OP_ADMIT;
                fill--;
            end else if (!cur_v)
                op = (rdy_cnt + io_cnt == 0 || r < 20) ? OP_ADMIT : OP_DISPATCH;
            else
                op = (r < 15) ? OP_ADMIT : OP_REPORT;
            send_item(op, pid, el, st, 1'b0, BLANK);
            sent++;
        end
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            mism++;
            if (mism <= 10)
                $display("%s mismatch at result %0d: expected %0h, got %0h",
                         name, n_results, want, got);
        end
    endtask

    task automatic check_result();
        sched_result_t got, want;
        got = '{m_tuser[0], m_tdata[3:0], m_tdata[4], m_tuser[1], m_tdata[8:5],
                m_tdata[40:9], m_tdata[72:41], m_tdata[104:73]};
        n_results++;
        if (exp_cnt == 0) begin
            mism++;
            if (mism <= 10)
                $display("result %0d arrived with nothing expected", n_results);
        end else begin
            want = exp_buf[exp_head];
            exp_head = (exp_head + 1) % EXP_DEPTH;
            exp_cnt--;
            cmp_field("running_valid", want.run_v, got.run_v);
            cmp_field("running_process", want.run_p, got.run_p);
            cmp_field("all_done", want.all_done, got.all_done);
            cmp_field("retired_valid", want.ret_v, got.ret_v);
            cmp_field("retired_process", want.ret_p, got.ret_p);
            cmp_field("retired_wait_time", want.ret_w, got.ret_w);
            cmp_field("retired_io_time", want.ret_io, got.ret_io);
            cmp_field("clock_now", want.clk_now, got.clk_now);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
    end

    // receiver: free-flowing, short random stalls, or long stalls
    int rx_cyc = 0, rx_mode = 0, rx_hold = 0;

    always @(negedge clk)
    begin
        rx_cyc <= rx_cyc + 1;
        if (rx_cyc % 256 == 0)
            rx_mode <= $urandom_range(0, 2);
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (rx_mode == 1 && $urandom_range(0, 2) == 0)
                rx_hold <= $urandom_range(1, 3);
            else if (rx_mode == 2 && $urandom_range(0, 7) == 0)
                rx_hold <= $urandom_range(4, 16);
        end
    end

    int idle_cyc = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= STALL_LIMIT) begin
            $display("round_robin_io_wait_scheduler verification failed");
            $finish;
        end
    end

    dir_row_t dir_table [20];

    initial
    begin
        dir_table = '{
            '{OP_REPORT, 4'd0, 16'hFFFF, ST_SLICE_END, 1'b1,
              '{1'b0, 4'd0, 1'b1, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0}},
            '{OP_DISPATCH, 4'd0, 16'd0, ST_SLICE_END, 1'b1,
              '{1'b0, 4'd0, 1'b1, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0}},
            '{OP_UNUSED, 4'd15, 16'hFFFF, ST_WRITE, 1'b1,
              '{1'b0, 4'd0, 1'b1, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0}},
            '{OP_ADMIT, 4'd15, 16'd0, ST_SLICE_END, 1'b1,
              '{1'b0, 4'd0, 1'b0, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0}},
            '{OP_ADMIT, 4'd0, 16'hFFFF, ST_WRITE, 1'b1,
              '{1'b0, 4'd0, 1'b0, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0}},
            '{OP_DISPATCH, 4'd0, 16'd0, ST_SLICE_END, 1'b1,
              '{1'b1, 4'd15, 1'b0, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0}},
            // dispatch while a process is running
            '{OP_DISPATCH, 4'd5, 16'd0, ST_SLICE_END, 1'b1,
              '{1'b0, 4'd0, 1'b0, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0}},
            '{OP_REPORT, 4'd0, 16'hFFFF, ST_SLICE_END, 1'b1,
              '{1'b1, 4'd0, 1'b0, 1'b0, 4'd0, 32'd0, 32'd0, 32'd65540}},
            '{OP_REPORT, 4'd0, 16'd0, ST_READ, 1'b1,
              '{1'b1, 4'd15, 1'b0, 1'b0, 4'd0, 32'd0, 32'd0, 32'd65545}},
            // halt, then the clock idles forward to the waiter
            '{OP_REPORT, 4'd0, 16'd0, ST_HALT, 1'b0, BLANK},
            '{OP_REPORT, 4'd0, 16'd100, ST_WRITE, 1'b0, BLANK},
            '{OP_REPORT, 4'd0, 16'd0, ST_BOUNDS, 1'b0, BLANK},
            '{OP_ADMIT, 4'd1, 16'd0, ST_SLICE_END, 1'b0, BLANK},
            '{OP_ADMIT, 4'd2, 16'd0, ST_SLICE_END, 1'b0, BLANK},
            '{OP_ADMIT, 4'd3, 16'd0, ST_SLICE_END, 1'b0, BLANK},
            '{OP_DISPATCH, 4'd0, 16'd0, ST_SLICE_END, 1'b0, BLANK},
            '{OP_REPORT, 4'd0, 16'd7, ST_OVERFLOW, 1'b0, BLANK},
            '{OP_REPORT, 4'd0, 16'd9, ST_UNDERFLOW, 1'b0, BLANK},
            '{OP_REPORT, 4'd0, 16'd11, ST_BAD_OPCODE, 1'b0, BLANK},
            '{OP_UNUSED, 4'd10, 16'h5A5A, ST_READ, 1'b0, BLANK}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
            send_item(dir_table[i].op, dir_table[i].pid, dir_table[i].el, dir_table[i].st,
                      dir_table[i].typed, dir_table[i].want);

        run_phase(8'd0, 16'd0, 290, 30, 50);
        run_phase(8'd255, 16'hFFFF, 280, 70, 90);
        run_phase(8'($urandom), 16'($urandom), 280, 30, 40);
        run_phase(SWO_RESET, IOL_RESET, 265, 35, 60);
        run_phase(8'($urandom_range(0, 15)), 16'($urandom_range(0, 300)), 265, 45, 85);

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d items, %0d results: %0d dispatches, %0d retirements, %0d I/O parks",
                 n_items, n_results, n_dispatched, n_retired, n_parked);
        $display("clock idled forward %0d times, %0d processes dropped on a full queue",
                 n_idle_fwd, n_dropped);
        if (mism == 0)
            $display("round_robin_io_wait_scheduler verification clean");
        else
            $display("round_robin_io_wait_scheduler verification failed");
        $finish;
    end

endmodule
